@@ rtl/core/sll_pkg.sv @@
// Shared types and constants of the static linked list engine.
// Request and status codes, port widths, controller states and the
// command and status bundles between controller and datapath.
package sll_pkg;

    localparam int POS_W      = 10;
    localparam int VAL_W      = 32;
    localparam int SLOT_W     = 10;
    localparam int CNT_W      = 10;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_PAD_W  = OUT_DATA_W - CNT_W - VAL_W - SLOT_W;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_READ   = 2'd2,
        REQ_SEARCH = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    typedef enum logic [7:0] {
        S_CLEAR      = 8'b0000_0001,
        S_IDLE       = 8'b0000_0010,
        S_CHECK      = 8'b0000_0100,
        S_WALK       = 8'b0000_1000,
        S_INS_FIN    = 8'b0001_0000,
        S_DEL_UNLINK = 8'b0010_0000,
        S_DEL_FREE   = 8'b0100_0000,
        S_RESP       = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic walk_start;
        logic walk_step;
        logic ins_link;
        logic ins_fin;
        logic del_rd;
        logic del_unlink;
        logic del_free;
        logic set_range;
        logic set_full;
        logic set_miss;
        logic set_found;
        logic set_read;
        logic emit;
    } cmd_t;

    typedef struct packed {
        req_t req;
        logic clr_last;
        logic range_err;
        logic full;
        logic walk_done;
        logic search_hit;
        logic search_end;
        logic out_free;
    } stat_t;

endpackage

@@ rtl/core/sll_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/sll_ctrl.sv @@
// Controller state machine of the static linked list engine.
// Depends on sll_pkg; drives the datapath through cmd_t and reads stat_t.
module sll_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  sll_pkg::stat_t stat,
    output sll_pkg::cmd_t  cmd
);

    import sll_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.req == REQ_SEARCH)
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_WALK;
                end
                else if (stat.range_err)
                begin
                    cmd.set_range = 1'b1;
                    state_next    = S_RESP;
                end
                else if (stat.req == REQ_INSERT && stat.full)
                begin
                    cmd.set_full = 1'b1;
                    state_next   = S_RESP;
                end
                else
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_WALK;
                end
            end
            S_WALK:
            begin
                if (stat.req == REQ_SEARCH)
                begin
                    if (stat.search_hit)
                    begin
                        cmd.set_found = 1'b1;
                        state_next    = S_RESP;
                    end
                    else if (stat.search_end)
                    begin
                        cmd.set_miss = 1'b1;
                        state_next   = S_RESP;
                    end
                    else
                    begin
                        cmd.walk_step = 1'b1;
                    end
                end
                else if (stat.walk_done)
                begin
                    unique case (stat.req)
                        REQ_INSERT:
                        begin
                            cmd.ins_link = 1'b1;
                            state_next   = S_INS_FIN;
                        end
                        REQ_DELETE:
                        begin
                            cmd.del_rd = 1'b1;
                            state_next = S_DEL_UNLINK;
                        end
                        default:
                        begin
                            cmd.set_read = 1'b1;
                            state_next   = S_RESP;
                        end
                    endcase
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_INS_FIN:
            begin
                cmd.ins_fin = 1'b1;
                state_next  = S_RESP;
            end
            S_DEL_UNLINK:
            begin
                cmd.del_unlink = 1'b1;
                state_next     = S_DEL_FREE;
            end
            S_DEL_FREE:
            begin
                cmd.del_free = 1'b1;
                state_next   = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/sll_dp.sv @@
// Datapath of the static linked list engine: link and value stores,
// walk cursor, free chain head, element count and the output register.
// Depends on sll_pkg and sll_ram.
module sll_dp #(
    parameter int SLOTS = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sll_pkg::cmd_t                    cmd,
    output sll_pkg::stat_t                   stat,
    input  logic [sll_pkg::IN_DATA_W-1:0]    in_data,
    input  logic [1:0]                       in_user,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [sll_pkg::OUT_DATA_W-1:0]   out_data,
    output logic [1:0]                       out_user
);

    import sll_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
    localparam logic [SW-1:0] HEAD_SLOT = SW'(1);
    localparam logic [SW-1:0] FIRST_ELEM = SW'(2);

    req_t                 req_reg, req_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [POS_W-1:0]     target_reg, target_next;
    logic [VAL_W-1:0]     value_reg, value_next;
    logic [SW-1:0]        cur_reg, cur_next;
    logic [SW-1:0]        k_reg, k_next;
    logic [SW-1:0]        aux_reg, aux_next;
    logic [SW-1:0]        free_head_reg, free_head_next;
    logic [SW-1:0]        count_reg, count_next;
    logic [SW-1:0]        clr_idx_reg, clr_idx_next;
    status_t              status_reg, status_next;
    logic [SW-1:0]        slot_reg, slot_next;
    logic [VAL_W-1:0]     rval_reg, rval_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [1:0]           out_user_reg, out_user_next;

    logic                 link_we;
    logic [SW-1:0]        link_waddr;
    logic [SW-1:0]        link_wdata;
    logic [SW-1:0]        link_q;
    logic                 val_we;
    logic [SW-1:0]        val_waddr;
    logic [SW-1:0]        raddr;
    logic [VAL_W-1:0]     val_q;
    logic [SW-1:0]        clr_init;
    logic [31:0]          cnt_ext;
    logic [31:0]          pos_ext;
    logic [31:0]          slot_ext;
    logic                 out_free;

    sll_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (raddr),
        .rdata (link_q)
    );

    sll_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (value_reg),
        .raddr (raddr),
        .rdata (val_q)
    );

    assign cnt_ext  = 32'(count_reg);
    assign pos_ext  = 32'(pos_reg);
    assign slot_ext = 32'(slot_reg);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        if (clr_idx_reg == '0)
        begin
            clr_init = FIRST_ELEM;
        end
        else if (clr_idx_reg == HEAD_SLOT || clr_idx_reg == LAST_SLOT)
        begin
            clr_init = '0;
        end
        else
        begin
            clr_init = clr_idx_reg + SW'(1);
        end
    end

    always_comb
    begin
        stat.req       = req_reg;
        stat.clr_last  = (clr_idx_reg == LAST_SLOT);
        if (req_reg == REQ_INSERT)
        begin
            stat.range_err = (pos_ext == 32'd0) || (pos_ext > cnt_ext + 32'd1);
        end
        else
        begin
            stat.range_err = (pos_ext == 32'd0) || (pos_ext > cnt_ext);
        end
        stat.full       = (free_head_reg == '0);
        stat.walk_done  = (32'(k_reg) == 32'(target_reg));
        stat.search_hit = (k_reg != '0) && (val_q == value_reg);
        stat.search_end = (k_reg == count_reg);
        stat.out_free   = out_free;
    end

    // Memory port selection.
    always_comb
    begin
        raddr      = cur_reg;
        link_we    = 1'b0;
        link_waddr = cur_reg;
        link_wdata = free_head_reg;
        val_we     = 1'b0;
        val_waddr  = free_head_reg;
        if (cmd.walk_start)
        begin
            raddr = HEAD_SLOT;
        end
        else if (cmd.walk_step || cmd.del_rd)
        begin
            raddr = link_q;
        end
        else if (cmd.ins_link)
        begin
            raddr = free_head_reg;
        end
        if (cmd.clr_step)
        begin
            link_we    = 1'b1;
            link_waddr = clr_idx_reg;
            link_wdata = clr_init;
        end
        else if (cmd.ins_link)
        begin
            link_we    = 1'b1;
            link_waddr = cur_reg;
            link_wdata = free_head_reg;
            val_we     = 1'b1;
        end
        else if (cmd.ins_fin)
        begin
            link_we    = 1'b1;
            link_waddr = free_head_reg;
            link_wdata = aux_reg;
        end
        else if (cmd.del_unlink)
        begin
            link_we    = 1'b1;
            link_waddr = cur_reg;
            link_wdata = link_q;
        end
        else if (cmd.del_free)
        begin
            link_we    = 1'b1;
            link_waddr = aux_reg;
            link_wdata = free_head_reg;
        end
    end

    always_comb
    begin
        req_next       = req_reg;
        pos_next       = pos_reg;
        target_next    = target_reg;
        value_next     = value_reg;
        cur_next       = cur_reg;
        k_next         = k_reg;
        aux_next       = aux_reg;
        free_head_next = free_head_reg;
        count_next     = count_reg;
        clr_idx_next   = clr_idx_reg;
        status_next    = status_reg;
        slot_next      = slot_reg;
        rval_next      = rval_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;

        if (cmd.clr_step)
        begin
            clr_idx_next = clr_idx_reg + SW'(1);
        end
        if (cmd.accept)
        begin
            req_next    = req_t'(in_user);
            pos_next    = in_data[POS_W-1:0];
            value_next  = in_data[POS_W +: VAL_W];
            status_next = ST_OK;
            slot_next   = '0;
            rval_next   = '0;
            if (req_t'(in_user) == REQ_READ)
            begin
                target_next = in_data[POS_W-1:0];
            end
            else
            begin
                target_next = in_data[POS_W-1:0] - POS_W'(1);
            end
        end
        if (cmd.walk_start)
        begin
            cur_next = HEAD_SLOT;
            k_next   = '0;
        end
        if (cmd.walk_step)
        begin
            cur_next = link_q;
            k_next   = k_reg + SW'(1);
        end
        if (cmd.ins_link)
        begin
            aux_next = link_q;
        end
        if (cmd.ins_fin)
        begin
            free_head_next = link_q;
            count_next     = count_reg + SW'(1);
            slot_next      = free_head_reg;
        end
        if (cmd.del_rd)
        begin
            aux_next = link_q;
        end
        if (cmd.del_unlink)
        begin
            rval_next = val_q;
        end
        if (cmd.del_free)
        begin
            free_head_next = aux_reg;
            count_next     = count_reg - SW'(1);
        end
        if (cmd.set_range)
        begin
            status_next = ST_RANGE;
        end
        if (cmd.set_full)
        begin
            status_next = ST_FULL;
        end
        if (cmd.set_miss)
        begin
            status_next = ST_MISS;
        end
        if (cmd.set_found)
        begin
            slot_next = cur_reg;
        end
        if (cmd.set_read)
        begin
            rval_next = val_q;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {OUT_PAD_W'(0), cnt_ext[CNT_W-1:0], rval_reg,
                              slot_ext[SLOT_W-1:0]};
            out_user_next  = status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg <= FIRST_ELEM;
            count_reg     <= '0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        pos_reg      <= pos_next;
        target_reg   <= target_next;
        value_reg    <= value_next;
        cur_reg      <= cur_next;
        k_reg        <= k_next;
        aux_reg      <= aux_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        rval_reg     <= rval_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;

endmodule

@@ rtl/core/static_linked_list_engine_unit.sv @@
// Top level of the static linked list engine.
// Depends on sll_pkg, sll_ctrl and sll_dp (which holds two sll_ram stores).
//
// A singly linked list in a store of SLOTS slots: slot 0 serves as the
// null link, a register holds the head of the free chain and slot 1
// heads the list, so at most SLOTS-2 elements fit. After reset the block
// initializes the link store and holds s_axis_tready low meanwhile. One
// request is worked at a time and s_axis_tready is high only while the
// block is idle. The walk along the list advances one link per cycle,
// paced by the registered read of the link store. The block returns to
// idle as the result register is loaded, and the result register lets
// the next request be accepted while a result still waits on the master
// side.
module static_linked_list_engine_unit #(
    parameter int SLOTS = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // position [9:0], value [41:10], zero fill [47:42]
    input  logic [sll_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // req_type [1:0]
    input  logic [1:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // slot [9:0], result_value [41:10], list_count [51:42], zero fill [55:52]
    output logic [sll_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // status [1:0]
    output logic [1:0]                       m_axis_tuser
);

    import sll_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    sll_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sll_dp #(.SLOTS(SLOTS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule

@@ rtl/core/sll_chk.sv @@
// Port-level checker of the static linked list engine, bound to the top.
// Depends on sll_pkg and static_linked_list_engine_unit.
module sll_chk #(
    parameter int SLOTS = 1024
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [sll_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input logic [1:0]                       s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [sll_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input logic [1:0]                       m_axis_tuser
);

    import sll_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while another is in progress");

    a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tdata[41:0] == 42'd0)
        else $error("failed request carries a slot or value");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_FULL) |->
            m_axis_tdata[51:42] == 10'(SLOTS - 2))
        else $error("store full reported below capacity");

endmodule

bind static_linked_list_engine_unit sll_chk #(.SLOTS(SLOTS)) u_sll_chk (.*);
